>>> design/assert_macros.svh
// Assertion macros used by the allocator top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FFAH_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// The consequent must hold in the cycle after the antecedent.
`define FFAH_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

>>> design/ffah_pkg.sv
// Types and constants used by the heap allocator top level.
package ffah_pkg;

  localparam int MAX_SEGMENTS_DEF = 64;
  localparam int DEF_ALIGN        = 16;
  localparam int GRAIN_BYTES      = 8;
  localparam int MIN_ALIGN        = 4;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_REALLOC = 2'd1,
    OP_FREE    = 2'd2,
    OP_QUERY   = 2'd3
  } ffah_op_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NOT_INIT   = 3'd1,
    ST_BAD_ALIGN  = 3'd2,
    ST_OVERFLOW   = 3'd3,
    ST_NO_MEM     = 3'd4,
    ST_NOT_LIVE   = 3'd5,
    ST_TABLE_FULL = 3'd6
  } ffah_status_t;

  typedef enum logic {
    REG_HEAP_BASE = 1'b0,
    REG_HEAP_SIZE = 1'b1
  } ffah_reg_t;

  typedef struct packed {
    ffah_op_t    op;
    logic [31:0] address;
    logic [31:0] request_size;
    logic [31:0] alignment;
  } ffah_in_t;

  typedef struct packed {
    ffah_status_t status;
    logic [31:0]  result_address;
    logic [31:0]  result_size;
    logic [31:0]  bytes_live;
    logic [31:0]  bytes_peak;
    logic [31:0]  allocations_done;
    logic [31:0]  frees_done;
    logic [31:0]  reallocs_seen;
  } ffah_out_t;

  typedef struct packed {
    logic        used;
    logic [31:0] start;
    logic [31:0] len;
  } ffah_seg_t;

endpackage

>>> design/ffah_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module ffah_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/first_fit_aligned_heap_allocator_unit.sv
// Top level of the first-fit aligned heap allocator with coalescing.
//
// Requests enter on in_item when start is high and busy is low; busy stays
// high until the cycle in which the single result is shown. The result appears
// on out_item for one cycle with out_valid high and cannot be held off by the
// receiver. heap_base (byte 0) and heap_size (byte 4) are written over APB,
// by the user only while the block is idle (not enforced by the block); a
// write rebuilds the table as one free segment and clears the live byte count.
// The segment table sits in one RAM with a single registered read port, and
// one sequencer walks it. A lookup, an allocate scan, the opening of table
// slots by moving entries up, and the coalescing pass after a free or shrink
// each visit the entries one at a time, between setup and the result state.
// After reset, and after a configuration write, the first request writes
// table entry zero before its dispatch. Reset leaves one free segment, zero
// statistics and no result pending.
`include "assert_macros.svh"

module first_fit_aligned_heap_allocator_unit
  import ffah_pkg::*;
#(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  ffah_in_t    in_item,
  output logic        out_valid,
  output ffah_out_t   out_item,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam logic [CW:0] MAX_C = (CW + 1)'(MAX_SEGMENTS);
  localparam logic [32:0] GRAIN_M1 = 33'(GRAIN_BYTES - 1);

  typedef enum logic [4:0] {
    S_IDLE, S_INIT, S_DISP, S_ACHK, S_AREQ, S_ACALC, S_AFIT, S_ADONE,
    S_FREQ, S_FCHK, S_RSREQ, S_RSCHK, S_RSNOM, S_SHREQ, S_SHWR, S_WR,
    S_MGREQ, S_MGPROC, S_MGLAST, S_FIN
  } state_t;

  typedef enum logic [1:0] {FM_FREE, FM_QUERY, FM_REALLOC} fmode_t;
  typedef enum logic {PO_ALLOC, PO_MERGE} post_t;

  state_t       state_r, state_nxt;
  fmode_t       fmode_r, fmode_nxt;
  post_t        post_r, post_nxt;
  logic         grow_r, grow_nxt;
  logic         init_pend_r, init_pend_nxt;
  logic [CW-1:0] total_r, total_nxt;
  logic [31:0]  base_r, base_nxt, size_r, size_nxt;
  logic [31:0]  live_r, live_nxt, peak_r, peak_nxt;
  logic [31:0]  alloc_cnt_r, alloc_cnt_nxt, free_cnt_r, free_cnt_nxt;
  logic [31:0]  realloc_cnt_r, realloc_cnt_nxt;
  logic         out_valid_r, out_valid_nxt;

  ffah_in_t     in_r, in_nxt;
  ffah_out_t    out_r, out_nxt;
  ffah_status_t status_r, status_nxt;
  logic [31:0]  raddr_r, raddr_nxt, rsize_r, rsize_nxt;
  logic [31:0]  al_r, al_nxt, rsz_r, rsz_nxt, s_r, s_nxt;
  logic [31:0]  old_r, old_nxt, diff_r, diff_nxt;
  logic [32:0]  a_r, a_nxt, bend_r, bend_nxt;
  logic [CW-1:0] idx_r, idx_nxt, p_r, p_nxt, sh_cur_r, sh_cur_nxt;
  logic [CW-1:0] wbase_r, wbase_nxt, mg_rd_r, mg_rd_nxt, mg_wr_r, mg_wr_nxt;
  logic [1:0]   k_r, k_nxt, wsel_r, wsel_nxt, wlast_r, wlast_nxt;
  logic         mg_first_r, mg_first_nxt;
  ffah_seg_t    wq0_r, wq0_nxt, wq1_r, wq1_nxt, wq2_r, wq2_nxt;
  ffah_seg_t    pend_r, pend_nxt;

  logic          ram_we;
  logic [IW-1:0] ram_waddr, ram_raddr;
  ffah_seg_t     ram_wdata, ram_rdata;

  ffah_ram #(
    .WIDTH ($bits(ffah_seg_t)),
    .DEPTH (MAX_SEGMENTS)
  ) u_seg_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == REG_HEAP_SIZE) ? size_r : base_r;

  always_comb begin
    ffah_seg_t     cur;
    logic [32:0]   room;
    logic [31:0]   al_eff, al_m1, eff, live_sum;
    logic [32:0]   rnd;
    logic [33:0]   end34;
    logic          fit, lead, tail;
    logic [1:0]    extra;
    logic [CW-1:0] sh_dst, wr_dst;
    ffah_seg_t     wsel_seg;

    cur      = ram_rdata;
    room     = 33'h1_0000_0000 - {1'b0, base_r};
    al_eff   = (al_r == 32'd0) ? 32'(DEF_ALIGN) : al_r;
    al_m1    = al_r - 32'd1;
    eff      = (in_r.request_size == 32'd0) ? 32'd1 : in_r.request_size;
    rnd      = ({1'b0, eff} + GRAIN_M1) & ~GRAIN_M1;
    end34    = {1'b0, a_r} + {2'b00, rsz_r};
    fit      = !a_r[32] && (end34 <= {1'b0, bend_r});
    lead     = (a_r[31:0] != s_r);
    tail     = (end34 < {1'b0, bend_r});
    extra    = {1'b0, lead} + {1'b0, tail};
    live_sum = live_r + rsz_r;
    sh_dst   = sh_cur_r + CW'(k_r);
    wr_dst   = wbase_r + CW'(wsel_r);
    case (wsel_r)
      2'd0:    wsel_seg = wq0_r;
      2'd1:    wsel_seg = wq1_r;
      default: wsel_seg = wq2_r;
    endcase

    state_nxt = state_r;  fmode_nxt = fmode_r;  post_nxt = post_r;
    grow_nxt = grow_r;  init_pend_nxt = init_pend_r;  total_nxt = total_r;
    base_nxt = base_r;  size_nxt = size_r;  live_nxt = live_r;
    peak_nxt = peak_r;  alloc_cnt_nxt = alloc_cnt_r;  free_cnt_nxt = free_cnt_r;
    realloc_cnt_nxt = realloc_cnt_r;  out_valid_nxt = 1'b0;
    in_nxt = in_r;  out_nxt = out_r;  status_nxt = status_r;
    raddr_nxt = raddr_r;  rsize_nxt = rsize_r;  al_nxt = al_r;
    rsz_nxt = rsz_r;  s_nxt = s_r;  old_nxt = old_r;  diff_nxt = diff_r;
    a_nxt = a_r;  bend_nxt = bend_r;  idx_nxt = idx_r;  p_nxt = p_r;
    sh_cur_nxt = sh_cur_r;  wbase_nxt = wbase_r;  mg_rd_nxt = mg_rd_r;
    mg_wr_nxt = mg_wr_r;  k_nxt = k_r;  wsel_nxt = wsel_r;  wlast_nxt = wlast_r;
    mg_first_nxt = mg_first_r;  wq0_nxt = wq0_r;  wq1_nxt = wq1_r;
    wq2_nxt = wq2_r;  pend_nxt = pend_r;
    ram_we = 1'b0;  ram_waddr = '0;  ram_wdata = '0;  ram_raddr = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          in_nxt     = in_item;
          status_nxt = ST_OK;
          raddr_nxt  = 32'd0;
          rsize_nxt  = 32'd0;
          grow_nxt   = 1'b0;
          state_nxt  = init_pend_r ? S_INIT : S_DISP;
        end
      end
      S_INIT: begin
        ram_we        = 1'b1;
        ram_wdata     = '{used: 1'b0, start: base_r,
                          len: ({1'b0, size_r} > room) ? room[31:0] : size_r};
        init_pend_nxt = 1'b0;
        state_nxt     = S_DISP;
      end
      S_DISP: begin
        idx_nxt = '0;
        case (in_r.op)
          OP_ALLOC: begin
            al_nxt    = in_r.alignment;
            state_nxt = S_ACHK;
          end
          OP_REALLOC: begin
            realloc_cnt_nxt = realloc_cnt_r + 32'd1;
            if (in_r.address == 32'd0) begin
              al_nxt    = 32'(DEF_ALIGN);
              state_nxt = S_ACHK;
            end else if (in_r.request_size == 32'd0) begin
              fmode_nxt = FM_FREE;
              state_nxt = S_FREQ;
            end else begin
              fmode_nxt = FM_REALLOC;
              state_nxt = S_FREQ;
            end
          end
          OP_FREE: begin
            fmode_nxt = FM_FREE;
            state_nxt = (in_r.address == 32'd0) ? S_FIN : S_FREQ;
          end
          OP_QUERY: begin
            fmode_nxt = FM_QUERY;
            state_nxt = (in_r.address == 32'd0) ? S_FIN : S_FREQ;
          end
          default: state_nxt = S_FIN;
        endcase
      end
      S_ACHK: begin
        idx_nxt = '0;
        if (base_r == 32'd0 || size_r == 32'd0) begin
          status_nxt = ST_NOT_INIT;
          state_nxt  = S_FIN;
        end else if (al_eff < 32'(MIN_ALIGN) || (al_eff & (al_eff - 32'd1)) != 32'd0) begin
          status_nxt = ST_BAD_ALIGN;
          state_nxt  = S_FIN;
        end else if (rnd[32]) begin
          status_nxt = ST_OVERFLOW;
          state_nxt  = S_FIN;
        end else begin
          rsz_nxt   = rnd[31:0];
          al_nxt    = al_eff;
          state_nxt = S_AREQ;
        end
      end
      S_AREQ: begin
        ram_raddr = idx_r[IW-1:0];
        state_nxt = S_ACALC;
      end
      S_ACALC: begin
        if (cur.used) begin
          idx_nxt = idx_r + 1'b1;
          if (idx_r + 1'b1 == total_r) begin
            status_nxt = ST_NO_MEM;
            state_nxt  = S_FIN;
          end else begin
            state_nxt = S_AREQ;
          end
        end else begin
          s_nxt     = cur.start;
          a_nxt     = ({1'b0, cur.start} + {1'b0, al_m1}) & ~{1'b0, al_m1};
          bend_nxt  = {1'b0, cur.start} + {1'b0, cur.len};
          state_nxt = S_AFIT;
        end
      end
      S_AFIT: begin
        if (!fit) begin
          idx_nxt = idx_r + 1'b1;
          if (idx_r + 1'b1 == total_r) begin
            status_nxt = ST_NO_MEM;
            state_nxt  = S_FIN;
          end else begin
            state_nxt = S_AREQ;
          end
        end else if (({1'b0, total_r} + (CW + 1)'(extra)) > MAX_C) begin
          status_nxt = ST_TABLE_FULL;
          state_nxt  = S_FIN;
        end else begin
          // Leftover in front stays free in place; piece and tail follow it.
          if (lead) begin
            wq0_nxt   = '{used: 1'b0, start: s_r, len: a_r[31:0] - s_r};
            wq1_nxt   = '{used: 1'b1, start: a_r[31:0], len: rsz_r};
            wq2_nxt   = '{used: 1'b0, start: end34[31:0],
                          len: bend_r[31:0] - end34[31:0]};
            wlast_nxt = tail ? 2'd2 : 2'd1;
          end else begin
            wq0_nxt   = '{used: 1'b1, start: s_r, len: rsz_r};
            wq1_nxt   = '{used: 1'b0, start: end34[31:0],
                          len: bend_r[31:0] - end34[31:0]};
            wlast_nxt = tail ? 2'd1 : 2'd0;
          end
          raddr_nxt  = a_r[31:0];
          wbase_nxt  = idx_r;
          k_nxt      = extra;
          p_nxt      = idx_r + 1'b1;
          post_nxt   = PO_ALLOC;
          wsel_nxt   = 2'd0;
          sh_cur_nxt = total_r - 1'b1;
          state_nxt  = (extra != 2'd0 && total_r > idx_r + 1'b1) ? S_SHREQ : S_WR;
        end
      end
      S_SHREQ: begin
        ram_raddr = sh_cur_r[IW-1:0];
        state_nxt = S_SHWR;
      end
      S_SHWR: begin
        ram_we    = 1'b1;
        ram_waddr = sh_dst[IW-1:0];
        ram_wdata = cur;
        if (sh_cur_r == p_r) begin
          state_nxt = S_WR;
        end else begin
          sh_cur_nxt = sh_cur_r - 1'b1;
          state_nxt  = S_SHREQ;
        end
      end
      S_WR: begin
        ram_we    = 1'b1;
        ram_waddr = wr_dst[IW-1:0];
        ram_wdata = wsel_seg;
        if (wsel_r == wlast_r) begin
          total_nxt    = total_r + CW'(k_r);
          mg_rd_nxt    = '0;
          mg_wr_nxt    = '0;
          mg_first_nxt = 1'b1;
          state_nxt    = (post_r == PO_ALLOC) ? S_ADONE : S_MGREQ;
        end else begin
          wsel_nxt = wsel_r + 2'd1;
        end
      end
      S_ADONE: begin
        alloc_cnt_nxt = alloc_cnt_r + 32'd1;
        live_nxt      = live_sum;
        peak_nxt      = (live_sum > peak_r) ? live_sum : peak_r;
        if (grow_r) begin
          // The new piece is in place; now release the old one.
          fmode_nxt = FM_FREE;
          idx_nxt   = '0;
          state_nxt = S_FREQ;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FREQ: begin
        ram_raddr = idx_r[IW-1:0];
        state_nxt = S_FCHK;
      end
      S_FCHK: begin
        if (cur.used && cur.start == in_r.address) begin
          case (fmode_r)
            FM_QUERY: begin
              rsize_nxt = cur.len;
              state_nxt = S_FIN;
            end
            FM_REALLOC: begin
              old_nxt = cur.len;
              if (in_r.request_size <= cur.len) begin
                if (rnd[31:0] < cur.len) begin
                  rsz_nxt   = rnd[31:0];
                  diff_nxt  = cur.len - rnd[31:0];
                  state_nxt = (idx_r + 1'b1 < total_r) ? S_RSREQ : S_RSNOM;
                end else begin
                  raddr_nxt = in_r.address;
                  state_nxt = S_FIN;
                end
              end else begin
                grow_nxt  = 1'b1;
                al_nxt    = 32'(DEF_ALIGN);
                state_nxt = S_ACHK;
              end
            end
            default: begin
              wq0_nxt      = '{used: 1'b0, start: cur.start, len: cur.len};
              wlast_nxt    = 2'd0;
              wsel_nxt     = 2'd0;
              wbase_nxt    = idx_r;
              k_nxt        = 2'd0;
              live_nxt     = live_r - cur.len;
              free_cnt_nxt = free_cnt_r + 32'd1;
              post_nxt     = PO_MERGE;
              state_nxt    = S_WR;
            end
          endcase
        end else begin
          idx_nxt = idx_r + 1'b1;
          if (idx_r + 1'b1 == total_r) begin
            status_nxt = ST_NOT_LIVE;
            state_nxt  = S_FIN;
          end else begin
            state_nxt = S_FREQ;
          end
        end
      end
      S_RSREQ: begin
        ram_raddr = IW'(idx_r + 1'b1);
        state_nxt = S_RSCHK;
      end
      S_RSCHK: begin
        if (!cur.used && ({1'b0, in_r.address} + {1'b0, old_r}) == {1'b0, cur.start}) begin
          // The free neighbor behind grows down over the released tail.
          wq0_nxt   = '{used: 1'b1, start: in_r.address, len: rsz_r};
          wq1_nxt   = '{used: 1'b0, start: cur.start - diff_r, len: cur.len + diff_r};
          wlast_nxt = 2'd1;
          wsel_nxt  = 2'd0;
          wbase_nxt = idx_r;
          k_nxt     = 2'd0;
          live_nxt  = live_r - diff_r;
          raddr_nxt = in_r.address;
          post_nxt  = PO_MERGE;
          state_nxt = S_WR;
        end else begin
          state_nxt = S_RSNOM;
        end
      end
      S_RSNOM: begin
        if (total_r == MAX_C[CW-1:0]) begin
          status_nxt = ST_TABLE_FULL;
          state_nxt  = S_FIN;
        end else begin
          wq0_nxt    = '{used: 1'b1, start: in_r.address, len: rsz_r};
          wq1_nxt    = '{used: 1'b0, start: in_r.address + rsz_r, len: diff_r};
          wlast_nxt  = 2'd1;
          wsel_nxt   = 2'd0;
          wbase_nxt  = idx_r;
          k_nxt      = 2'd1;
          p_nxt      = idx_r + 1'b1;
          sh_cur_nxt = total_r - 1'b1;
          live_nxt   = live_r - diff_r;
          raddr_nxt  = in_r.address;
          post_nxt   = PO_MERGE;
          state_nxt  = (total_r > idx_r + 1'b1) ? S_SHREQ : S_WR;
        end
      end
      S_MGREQ: begin
        ram_raddr = mg_rd_r[IW-1:0];
        state_nxt = S_MGPROC;
      end
      S_MGPROC: begin
        // One pass compacts the table, folding touching free runs together.
        if (mg_first_r) begin
          pend_nxt     = cur;
          mg_first_nxt = 1'b0;
        end else if (!pend_r.used && !cur.used &&
                     ({1'b0, pend_r.start} + {1'b0, pend_r.len}) == {1'b0, cur.start}) begin
          pend_nxt.len = pend_r.len + cur.len;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = mg_wr_r[IW-1:0];
          ram_wdata = pend_r;
          mg_wr_nxt = mg_wr_r + 1'b1;
          pend_nxt  = cur;
        end
        if (mg_rd_r + 1'b1 == total_r) begin
          state_nxt = S_MGLAST;
        end else begin
          mg_rd_nxt = mg_rd_r + 1'b1;
          state_nxt = S_MGREQ;
        end
      end
      S_MGLAST: begin
        ram_we    = 1'b1;
        ram_waddr = mg_wr_r[IW-1:0];
        ram_wdata = pend_r;
        total_nxt = mg_wr_r + 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        out_valid_nxt            = 1'b1;
        out_nxt.status           = status_r;
        out_nxt.result_address   = (status_r == ST_OK) ? raddr_r : 32'd0;
        out_nxt.result_size      = rsize_r;
        out_nxt.bytes_live       = live_r;
        out_nxt.bytes_peak       = peak_r;
        out_nxt.allocations_done = alloc_cnt_r;
        out_nxt.frees_done       = free_cnt_r;
        out_nxt.reallocs_seen    = realloc_cnt_r;
        state_nxt                = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase

    if (psel && penable && pwrite) begin
      if (paddr[2] == REG_HEAP_SIZE) begin
        size_nxt = pwdata;
      end else begin
        base_nxt = pwdata;
      end
      init_pend_nxt = 1'b1;
      total_nxt     = CW'(1);
      live_nxt      = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      init_pend_r   <= 1'b1;
      total_r       <= CW'(1);
      base_r        <= 32'd0;
      size_r        <= 32'd0;
      live_r        <= 32'd0;
      peak_r        <= 32'd0;
      alloc_cnt_r   <= 32'd0;
      free_cnt_r    <= 32'd0;
      realloc_cnt_r <= 32'd0;
      out_valid_r   <= 1'b0;
      grow_r        <= 1'b0;
      fmode_r       <= FM_FREE;
      post_r        <= PO_ALLOC;
    end else begin
      state_r       <= state_nxt;
      init_pend_r   <= init_pend_nxt;
      total_r       <= total_nxt;
      base_r        <= base_nxt;
      size_r        <= size_nxt;
      live_r        <= live_nxt;
      peak_r        <= peak_nxt;
      alloc_cnt_r   <= alloc_cnt_nxt;
      free_cnt_r    <= free_cnt_nxt;
      realloc_cnt_r <= realloc_cnt_nxt;
      out_valid_r   <= out_valid_nxt;
      grow_r        <= grow_nxt;
      fmode_r       <= fmode_nxt;
      post_r        <= post_nxt;
    end
    in_r       <= in_nxt;
    out_r      <= out_nxt;
    status_r   <= status_nxt;
    raddr_r    <= raddr_nxt;
    rsize_r    <= rsize_nxt;
    al_r       <= al_nxt;
    rsz_r      <= rsz_nxt;
    s_r        <= s_nxt;
    old_r      <= old_nxt;
    diff_r     <= diff_nxt;
    a_r        <= a_nxt;
    bend_r     <= bend_nxt;
    idx_r      <= idx_nxt;
    p_r        <= p_nxt;
    sh_cur_r   <= sh_cur_nxt;
    wbase_r    <= wbase_nxt;
    mg_rd_r    <= mg_rd_nxt;
    mg_wr_r    <= mg_wr_nxt;
    k_r        <= k_nxt;
    wsel_r     <= wsel_nxt;
    wlast_r    <= wlast_nxt;
    mg_first_r <= mg_first_nxt;
    wq0_r      <= wq0_nxt;
    wq1_r      <= wq1_nxt;
    wq2_r      <= wq2_nxt;
    pend_r     <= pend_nxt;
  end

  `FFAH_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  `FFAH_ASSERT_NXT(a_strobe_single, clk, rst_n, out_valid, !out_valid)
  `FFAH_ASSERT_IMP(a_total_range, clk, rst_n, 1'b1, (total_r != '0) && ({1'b0, total_r} <= MAX_C))

endmodule
